// ===== src/pscie_pkg.sv =====
// Shared types, constants and CRC helpers for the PNG secret chunk block.
// No dependencies; used by pscie_ctrl, pscie_dp and the top level.
package pscie_pkg;

    localparam int TEXT_MAX = 48;
    localparam int TCNT_W   = $clog2(TEXT_MAX + 1);
    localparam int TIDX_W   = $clog2(TEXT_MAX);
    localparam int BIDX_W   = $clog2(TEXT_MAX + 12);

    localparam logic [2:0] ST_BYTE         = 3'd0;
    localparam logic [2:0] ST_BAD_SIG      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [2:0] ST_EMPTY_TEXT   = 3'd3;
    localparam logic [2:0] ST_SECRET_EMPTY = 3'd4;

    localparam logic [31:0] TYPE_IDAT = 32'h5441_4449;
    localparam logic [31:0] TYPE_IEND = 32'h444E_4549;
    localparam logic [7:0]  SEC_FIRST = 8'h73;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC
    } phase_t;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_FIRST,
        LD_EXTRA,
        LD_BURST
    } load_sel_t;

    // What one accepted item produces
    typedef struct packed {
        logic has_first;
        logic has_extra;
        logic extra_burst;
    } step_info_t;

    typedef struct packed {
        logic      accept;
        load_sel_t load_sel;
    } dp_cmd_t;

    typedef struct packed {
        step_info_t info;
        logic       burst_last;
    } dp_stat_t;

    function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? (32'hEDB8_8320 ^ (r >> 1)) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] sig_byte(logic [2:0] i);
        logic [7:0] v;
        unique case (i)
            3'd0: v = 8'd137;
            3'd1: v = 8'd80;
            3'd2: v = 8'd78;
            3'd3: v = 8'd71;
            3'd4: v = 8'd13;
            3'd5: v = 8'd10;
            3'd6: v = 8'd26;
            default: v = 8'd10;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] sec_byte(logic [1:0] i);
        logic [7:0] v;
        unique case (i)
            2'd0: v = 8'h73;
            2'd1: v = 8'h61;
            2'd2: v = 8'h4E;
            default: v = 8'h53;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_init();
        logic [31:0] c;
        c = 32'hFFFF_FFFF;
        for (int i = 0; i < 4; i++) begin
            c = crc_byte(c, sec_byte(i[1:0]));
        end
        return c;
    endfunction

    localparam logic [31:0] CRC_INIT = crc_init();

endpackage

// ===== src/pscie_ctrl.sv =====
// Emit sequencer: decides when an item is taken and which result loads the
// output register. Depends on pscie_pkg.
module pscie_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  pscie_pkg::dp_stat_t  stat,
    output pscie_pkg::dp_cmd_t   cmd
);
    import pscie_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_EXTRA,
        C_BURST
    } cstate_t;

    cstate_t state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == C_IDLE) && out_free);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.load_sel = LD_NONE;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.accept = 1'b1;
                    if (stat.info.has_first)
                        cmd.load_sel = LD_FIRST;
                    if (stat.info.has_extra)
                        state_next = stat.info.extra_burst ? C_BURST : C_EXTRA;
                end
            end
            C_EXTRA:
            begin
                if (out_free)
                begin
                    cmd.load_sel = LD_EXTRA;
                    state_next   = C_IDLE;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    cmd.load_sel = LD_BURST;
                    if (stat.burst_last)
                        state_next = C_IDLE;
                end
            end
        endcase
        if (cmd.load_sel != LD_NONE)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/pscie_dp.sv =====
// Parser registers, text store, running CRC and the output register.
// Depends on pscie_pkg; driven by pscie_ctrl commands.
module pscie_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    input  logic                 req_type,
    input  logic [7:0]           data_byte,
    input  pscie_pkg::dp_cmd_t   cmd,
    output pscie_pkg::dp_stat_t  stat,
    output logic [7:0]           out_byte,
    output logic [2:0]           status,
    output logic                 last
);
    import pscie_pkg::*;

    logic              mode_reg;
    phase_t            phase_reg, phase_next;
    logic [31:0]       cnt_reg, cnt_next;
    logic [31:0]       len_reg, len_next;
    logic [31:0]       typ_reg, typ_next;
    logic [TCNT_W-1:0] tcount_reg;
    logic [31:0]       crc_reg;
    logic              inserted_reg, inserted_next;
    logic              halted_reg, halted_next;
    logic              sig_bad_reg, sig_bad_next;
    logic [2:0]        extra_st_reg, extra_st_next;
    logic [BIDX_W-1:0] bidx_reg, bidx_next;
    logic [TCNT_W-1:0] tidx_reg, tidx_next;
    logic [7:0]        mem [TEXT_MAX];
    logic [7:0]        mem_q_reg;
    logic [TIDX_W-1:0] rd_addr;
    logic [7:0]        out_byte_reg;
    logic [2:0]        status_reg;
    logic              last_reg;

    logic [2:0]  first_st;
    logic        first_last;
    logic        stream;
    logic [31:0] typ_shift;
    logic [6:0]  text_end, burst_end, crc_pos;
    logic [31:0] crc_fin;
    logic [7:0]  burst_byte;
    logic        in_text;

    assign stream    = cmd.accept && !req_type && !halted_reg;
    assign typ_shift = {data_byte, typ_reg[31:8]};

    // Parse one stream byte
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        typ_next      = typ_reg;
        inserted_next = inserted_reg;
        halted_next   = halted_reg;
        sig_bad_next  = sig_bad_reg;
        extra_st_next = extra_st_reg;
        stat.info     = '0;
        first_st      = ST_BYTE;
        first_last    = 1'b0;
        if (!req_type && !halted_reg)
        begin
            if (phase_reg == PH_SIG && cnt_reg == 32'd0 && mode_reg
                && tcount_reg == '0)
            begin
                stat.info.has_first = 1'b1;
                first_st            = ST_EMPTY_TEXT;
                halted_next         = 1'b1;
            end
            else
            begin
                stat.info.has_first = mode_reg;
                unique case (phase_reg)
                    PH_SIG:
                    begin
                        sig_bad_next = sig_bad_reg
                                       || (data_byte != sig_byte(cnt_reg[2:0]));
                        cnt_next = cnt_reg + 32'd1;
                        if (cnt_reg[2:0] == 3'd7)
                        begin
                            cnt_next = '0;
                            if (sig_bad_next)
                            begin
                                halted_next = 1'b1;
                                if (mode_reg)
                                begin
                                    stat.info.has_extra = 1'b1;
                                    extra_st_next       = ST_BAD_SIG;
                                end
                                else
                                begin
                                    stat.info.has_first = 1'b1;
                                    first_st            = ST_BAD_SIG;
                                end
                            end
                            else
                                phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        len_next = {len_reg[23:0], data_byte};
                        cnt_next = cnt_reg + 32'd1;
                        if (cnt_reg[1:0] == 2'd3)
                        begin
                            cnt_next   = '0;
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        typ_next = typ_shift;
                        cnt_next = cnt_reg + 32'd1;
                        if (cnt_reg[1:0] == 2'd3)
                        begin
                            cnt_next = '0;
                            if (!mode_reg && typ_shift[7:0] == SEC_FIRST
                                && len_reg == 32'd0)
                            begin
                                stat.info.has_first = 1'b1;
                                first_st            = ST_SECRET_EMPTY;
                                halted_next         = 1'b1;
                            end
                            else
                                phase_next = (len_reg != 32'd0) ? PH_DATA : PH_CRC;
                        end
                    end
                    PH_DATA:
                    begin
                        cnt_next = cnt_reg + 32'd1;
                        if (!mode_reg && typ_reg[7:0] == SEC_FIRST)
                        begin
                            stat.info.has_first = 1'b1;
                            first_last = (cnt_next == len_reg);
                            if (first_last)
                                halted_next = 1'b1;
                        end
                        if (cnt_next == len_reg && !halted_next)
                        begin
                            cnt_next   = '0;
                            phase_next = PH_CRC;
                        end
                    end
                    default:
                    begin
                        cnt_next = cnt_reg + 32'd1;
                        if (cnt_reg[1:0] == 2'd3)
                        begin
                            cnt_next   = '0;
                            len_next   = '0;
                            phase_next = PH_LEN;
                            if (mode_reg && typ_reg == TYPE_IDAT && !inserted_reg)
                            begin
                                stat.info.has_extra = 1'b1;
                                if (tcount_reg == '0)
                                begin
                                    extra_st_next = ST_EMPTY_TEXT;
                                    halted_next   = 1'b1;
                                end
                                else
                                begin
                                    stat.info.extra_burst = 1'b1;
                                    inserted_next         = 1'b1;
                                end
                            end
                            if (typ_reg == TYPE_IEND)
                            begin
                                halted_next = 1'b1;
                                if (mode_reg)
                                    first_last = 1'b1;
                                else
                                begin
                                    stat.info.has_first = 1'b1;
                                    first_st            = ST_NOT_FOUND;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Insertion burst: length word, chunk type, text, CRC
    assign text_end  = 7'd8 + 7'(tcount_reg);
    assign burst_end = text_end + 7'd3;
    assign crc_pos   = 7'(bidx_reg) - text_end;
    assign crc_fin   = crc_reg ^ 32'hFFFF_FFFF;
    assign in_text   = (7'(bidx_reg) >= 7'd8) && (7'(bidx_reg) < text_end);
    assign stat.burst_last = (7'(bidx_reg) == burst_end);

    always_comb
    begin
        priority if (bidx_reg < BIDX_W'(3))
            burst_byte = 8'd0;
        else if (bidx_reg == BIDX_W'(3))
            burst_byte = 8'(tcount_reg);
        else if (bidx_reg < BIDX_W'(8))
            burst_byte = sec_byte(bidx_reg[1:0]);
        else if (in_text)
            burst_byte = mem_q_reg;
        else
        begin
            unique case (crc_pos[1:0])
                2'd0: burst_byte = crc_fin[31:24];
                2'd1: burst_byte = crc_fin[23:16];
                2'd2: burst_byte = crc_fin[15:8];
                default: burst_byte = crc_fin[7:0];
            endcase
        end
    end

    always_comb
    begin
        bidx_next = bidx_reg;
        tidx_next = tidx_reg;
        if (cmd.accept)
        begin
            bidx_next = '0;
            tidx_next = '0;
        end
        else if (cmd.load_sel == LD_BURST)
        begin
            bidx_next = bidx_reg + BIDX_W'(1);
            if (in_text)
                tidx_next = tidx_reg + TCNT_W'(1);
        end
    end

    assign rd_addr = (tidx_next < TCNT_W'(TEXT_MAX)) ? TIDX_W'(tidx_next) : '0;

    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[rd_addr];
        if (cmd.accept && req_type && tcount_reg < TCNT_W'(TEXT_MAX))
            mem[TIDX_W'(tcount_reg)] <= data_byte;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        unique case (cmd.load_sel)
            LD_FIRST:
            begin
                out_byte_reg <= (first_st == ST_BYTE) ? data_byte : 8'd0;
                status_reg   <= first_st;
                last_reg     <= first_last;
            end
            LD_EXTRA:
            begin
                out_byte_reg <= 8'd0;
                status_reg   <= extra_st_reg;
                last_reg     <= 1'b0;
            end
            LD_BURST:
            begin
                out_byte_reg <= burst_byte;
                status_reg   <= ST_BYTE;
                last_reg     <= 1'b0;
            end
            default:
            begin
                out_byte_reg <= out_byte_reg;
            end
        endcase
    end

    assign out_byte = out_byte_reg;
    assign status   = status_reg;
    assign last     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            phase_reg    <= PH_SIG;
            cnt_reg      <= '0;
            len_reg      <= '0;
            typ_reg      <= '0;
            tcount_reg   <= '0;
            crc_reg      <= CRC_INIT;
            inserted_reg <= 1'b0;
            halted_reg   <= 1'b0;
            sig_bad_reg  <= 1'b0;
            extra_st_reg <= ST_BYTE;
            bidx_reg     <= '0;
            tidx_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            if (stream)
            begin
                phase_reg    <= phase_next;
                cnt_reg      <= cnt_next;
                len_reg      <= len_next;
                typ_reg      <= typ_next;
                inserted_reg <= inserted_next;
                halted_reg   <= halted_next;
                sig_bad_reg  <= sig_bad_next;
                extra_st_reg <= extra_st_next;
            end
            if (cmd.accept && req_type && tcount_reg < TCNT_W'(TEXT_MAX))
            begin
                tcount_reg <= tcount_reg + TCNT_W'(1);
                crc_reg    <= crc_byte(crc_reg, data_byte);
            end
            bidx_reg <= bidx_next;
            tidx_reg <= tidx_next;
        end
    end

endmodule

// ===== src/png_secret_chunk_inserter_extractor.sv =====
// PNG secret chunk inserter / extractor, top level.
// A result is registered and shows in the cycle after its item is taken.
// One item per cycle while each gives at most one result and out_stall is low;
// a second result or the 12 + text length byte insertion burst holds in_stall
// until loaded into the single output register. Reset (async, low) clears the
// parser, text count and CRC; the text store holds no reset value.
module png_secret_chunk_inserter_extractor (
    input  logic       clk,
    input  logic       rst_n,
    // configuration: mode (0 extract, 1 insert)
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // input items
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    // result items
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [2:0] status,
    output logic       last
);
    import pscie_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration is always taken; the user writes it only while idle (unchecked)
    assign cfg_ready = 1'b1;

    // Sequencer: take an item only when idle and the output register is free,
    // then drain any follow-on results (error code or the inserted chunk).
    pscie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: chunk parser, text store with running CRC, output register
    pscie_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .req_type  (req_type),
        .data_byte (data_byte),
        .cmd       (cmd),
        .stat      (stat),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

endmodule
